/* sv/tsgr_pkg.sv */
// ----------------------------------------------------------------------------
// Touch strip gesture recognizer package
// Item layouts, configuration bundle, register indexes and action codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tsgr_pkg;

   // Pad coordinate that means the pad is not touched
   localparam logic [7:0] NO_TOUCH = 8'd255;

   // Region codes
   localparam logic [2:0] NO_REGION     = 3'd7;
   localparam logic [2:0] CENTER_REGION = 3'd4;
   localparam logic [2:0] LEFT_REGION   = 3'd0;
   localparam logic [2:0] RIGHT_REGION  = 3'd2;

   // Action codes
   localparam logic [3:0] ACT_NONE    = 4'd0;
   localparam logic [3:0] ACT_UP      = 4'd1;
   localparam logic [3:0] ACT_DOWN    = 4'd2;
   localparam logic [3:0] ACT_LEFT    = 4'd3;
   localparam logic [3:0] ACT_RIGHT   = 4'd4;
   localparam logic [3:0] ACT_LAUNCH0 = 4'd5;
   localparam logic [3:0] ACT_CENTER  = 4'd9;

   // Swipe mode codes
   localparam logic [2:0] MODE_LEFT_UP    = 3'd4;
   localparam logic [2:0] MODE_LEFT_DOWN  = 3'd5;
   localparam logic [1:0] SCROLL_NONE     = 2'd0;
   localparam logic [1:0] SCROLL_ONE      = 2'd1;
   localparam logic [1:0] SCROLL_TWO      = 2'd2;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] REG_SWIPE_POS   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SWIPE_NEG   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_TAP_WIN     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_DTAP_WIN    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_SWIPE_MODE  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_SPLIT_Y     = 3'd5;

   // Bus widths
   localparam int unsigned REQ_DATA_W = 72;
   localparam int unsigned RSP_DATA_W = 8;

   // Input item, first field in the highest bits
   typedef struct packed {
      logic        call_active;
      logic [31:0] timestamp_ms;
      logic        released;
      logic [7:0]  right_y;
      logic [7:0]  right_x;
      logic [7:0]  left_y;
      logic [7:0]  left_x;
   } req_item_type;

   // Result item, first field in the highest bits
   typedef struct packed {
      logic [1:0] scroll_mode;
      logic [3:0] action;
   } rsp_item_type;

   // Configuration bundle
   typedef struct packed {
      logic [7:0]        swipe_pos_threshold;
      logic signed [8:0] swipe_neg_threshold;
      logic [15:0]       tap_window_ms;
      logic [15:0]       double_tap_window_ms;
      logic [2:0]        swipe_mode;
      logic [7:0]        region_split_y;
   } cfg_type;

endpackage

`default_nettype wire

/* sv/touch_strip_gesture_recognizer_top.sv */
// ----------------------------------------------------------------------------
// Touch strip gesture recognizer top level
// Input register, gesture core and result register on stream channels.
// ----------------------------------------------------------------------------
// Each accepted touch event gives exactly one result item. An event passes
// through the input register and the core and lands in the result register,
// so one event is taken per clock while the result channel does not stall; the
// gesture state in the core is updated as the event moves into the result
// register. The only stall is backpressure on the result channel.
`default_nettype none

module touch_strip_gesture_recognizer_top (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // Input channel; tdata from bit 0: left_x, left_y, right_x, right_y,
   // released, timestamp_ms, call_active, zero fill
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [tsgr_pkg::REQ_DATA_W-1:0]  req_tdata,
   // Result channel; tdata from bit 0: action, scroll_mode, zero fill
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [tsgr_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // Configuration write port
   input  wire logic                             csr_we,
   input  wire logic [tsgr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [tsgr_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import tsgr_pkg::*;

   cfg_type      cfg;
   req_item_type in_item_ff;
   logic         in_valid_ff;
   rsp_item_type core_result;
   rsp_item_type out_item_ff;
   logic         out_valid_ff;
   logic         advance;

   // Item moves from input register to result register
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   tsgr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tsgr_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (advance),
      .item       (in_item_ff),
      .result     (core_result)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff <= req_tdata[$bits(req_item_type)-1:0];
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_item_ff <= core_result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - $bits(rsp_item_type)){1'b0}}, out_item_ff};

endmodule

`default_nettype wire

/* sv/tsgr_csr.sv */
// ----------------------------------------------------------------------------
// Touch strip gesture recognizer configuration registers
// Write-only register file with reset defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module tsgr_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [tsgr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [tsgr_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output tsgr_pkg::cfg_type                    cfg
);
   import tsgr_pkg::*;

   cfg_type cfg_ff, cfg_in;

   // Decode one register write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_SWIPE_POS:  cfg_in.swipe_pos_threshold  = csr_wdata[7:0];
            REG_SWIPE_NEG:  cfg_in.swipe_neg_threshold  = csr_wdata[8:0];
            REG_TAP_WIN:    cfg_in.tap_window_ms        = csr_wdata[15:0];
            REG_DTAP_WIN:   cfg_in.double_tap_window_ms = csr_wdata[15:0];
            REG_SWIPE_MODE: cfg_in.swipe_mode           = csr_wdata[2:0];
            REG_SPLIT_Y:    cfg_in.region_split_y       = csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.swipe_pos_threshold  <= 8'd20;
         cfg_ff.swipe_neg_threshold  <= -9'sd20;
         cfg_ff.tap_window_ms        <= 16'd300;
         cfg_ff.double_tap_window_ms <= 16'd500;
         cfg_ff.swipe_mode           <= 3'd3;
         cfg_ff.region_split_y       <= 8'd50;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* sv/tsgr_core.sv */
// ----------------------------------------------------------------------------
// Touch strip gesture recognizer core
// Gesture state and the single-pass swipe and tap decision for one item.
// ----------------------------------------------------------------------------
`default_nettype none

module tsgr_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  tsgr_pkg::cfg_type      cfg,
   input  wire logic              item_valid,
   input  tsgr_pkg::req_item_type item,
   output tsgr_pkg::rsp_item_type result
);
   import tsgr_pkg::*;

   // Gesture state
   logic        prev_valid_ff, prev_valid_in;
   logic [7:0]  prev_x_ff, prev_x_in;
   logic [7:0]  prev_y_ff, prev_y_in;
   logic        prev_left_ff, prev_left_in;
   logic [2:0]  down_region_ff, down_region_in;
   logic [2:0]  tap_region_ff, tap_region_in;
   logic [31:0] down_time_ff, down_time_in;
   logic [31:0] tap_time_ff, tap_time_in;
   logic        single_tap_ff, single_tap_in;

   logic              center, left_side, handled;
   logic [7:0]        pos_x, pos_y;
   logic signed [9:0] xd, yd, pos_thr, neg_thr;
   logic [8:0]        abs_xd, abs_yd;
   logic [2:0]        region;
   logic [31:0]       press_age, tap_age;
   logic              tap_ok, dtap_ok;
   logic [3:0]        action;
   logic [1:0]        mode;

   // Effective scroll mode for the side of the press
   function automatic logic [1:0] map_mode(input logic [2:0] sel, input logic left);
      logic [1:0] m;
      begin
         case (sel)
            3'd0, 3'd1, 3'd2, 3'd3: m = sel[1:0];
            MODE_LEFT_UP:           m = left ? SCROLL_ONE : SCROLL_TWO;
            MODE_LEFT_DOWN:         m = left ? SCROLL_TWO : SCROLL_ONE;
            default:                m = SCROLL_NONE;
         endcase
         return m;
      end
   endfunction

   // Position decode
   always_comb begin
      center    = (item.left_x == NO_TOUCH) && (item.left_y == NO_TOUCH) &&
                  (item.right_x == NO_TOUCH) && (item.right_y == NO_TOUCH);
      left_side = (item.left_x != NO_TOUCH) && (item.left_y != NO_TOUCH);
      pos_x     = left_side ? item.left_x : item.right_x;
      pos_y     = left_side ? item.left_y : item.right_y;
      region    = left_side ? LEFT_REGION : RIGHT_REGION;
      if (pos_y > cfg.region_split_y) region = region + 3'd1;
      if (center) region = CENTER_REGION;
   end

   // Differences and timing windows
   always_comb begin
      xd        = $signed({2'b00, pos_x}) - $signed({2'b00, prev_x_ff});
      yd        = $signed({2'b00, pos_y}) - $signed({2'b00, prev_y_ff});
      abs_xd    = xd[9] ? 9'(-xd) : xd[8:0];
      abs_yd    = yd[9] ? 9'(-yd) : yd[8:0];
      pos_thr   = $signed({2'b00, cfg.swipe_pos_threshold});
      neg_thr   = 10'(cfg.swipe_neg_threshold);
      press_age = item.timestamp_ms - down_time_ff;
      tap_age   = item.timestamp_ms - tap_time_ff;
      tap_ok    = (down_region_ff != NO_REGION) &&
                  (press_age < {16'd0, cfg.tap_window_ms});
      dtap_ok   = single_tap_ff && (tap_region_ff == region) &&
                  (tap_age < {16'd0, cfg.double_tap_window_ms});
   end

   // Gesture decision and next state
   always_comb begin
      prev_valid_in  = prev_valid_ff;
      prev_x_in      = prev_x_ff;
      prev_y_in      = prev_y_ff;
      prev_left_in   = prev_left_ff;
      down_region_in = down_region_ff;
      tap_region_in  = tap_region_ff;
      down_time_in   = down_time_ff;
      tap_time_in    = tap_time_ff;
      single_tap_in  = single_tap_ff;
      action         = ACT_NONE;
      mode           = SCROLL_NONE;
      handled        = 1'b0;

      if (!item.call_active) begin
         // Swipe test on release
         if (item.released) begin
            if (prev_valid_ff) begin
               if (center) begin
                  action = prev_left_ff ? ACT_RIGHT : ACT_LEFT;
               end else if (prev_left_ff == left_side) begin
                  if (abs_xd <= abs_yd) begin
                     if (yd > pos_thr)      action = ACT_DOWN;
                     else if (yd < neg_thr) action = ACT_UP;
                  end else begin
                     if (xd > pos_thr)      action = ACT_RIGHT;
                     else if (xd < neg_thr) action = ACT_LEFT;
                  end
               end
               if (action != ACT_NONE) begin
                  handled = 1'b1;
                  mode    = map_mode(cfg.swipe_mode, prev_left_ff);
               end
            end
            prev_valid_in = 1'b0;
         end else begin
            // Press or move
            if (!center) begin
               prev_left_in  = left_side;
               prev_x_in     = pos_x;
               prev_y_in     = pos_y;
               prev_valid_in = 1'b1;
            end
            down_region_in = region;
            down_time_in   = item.timestamp_ms;
         end

         // Tap tracking
         if (handled) begin
            down_region_in = NO_REGION;
            tap_region_in  = NO_REGION;
            tap_time_in    = 32'd0;
            single_tap_in  = 1'b0;
            down_time_in   = 32'd0;
         end else if (item.released) begin
            if (tap_ok && (region == down_region_ff)) begin
               if (dtap_ok) begin
                  action = (region < CENTER_REGION) ? ACT_LAUNCH0 + {1'b0, region}
                                                    : ACT_CENTER;
                  down_region_in = NO_REGION;
                  tap_region_in  = NO_REGION;
                  tap_time_in    = 32'd0;
                  single_tap_in  = 1'b0;
                  down_time_in   = 32'd0;
               end else begin
                  tap_region_in  = region;
                  down_region_in = region;
                  single_tap_in  = 1'b1;
                  tap_time_in    = down_time_ff;
               end
            end else begin
               down_region_in = NO_REGION;
               tap_region_in  = NO_REGION;
               tap_time_in    = 32'd0;
               single_tap_in  = 1'b0;
            end
         end
      end

      result.action      = action;
      result.scroll_mode = mode;
   end

   // State update once per item
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_valid_ff  <= 1'b0;
         prev_x_ff      <= 8'd0;
         prev_y_ff      <= 8'd0;
         prev_left_ff   <= 1'b0;
         down_region_ff <= NO_REGION;
         tap_region_ff  <= NO_REGION;
         down_time_ff   <= 32'd0;
         tap_time_ff    <= 32'd0;
         single_tap_ff  <= 1'b0;
      end else if (item_valid) begin
         prev_valid_ff  <= prev_valid_in;
         prev_x_ff      <= prev_x_in;
         prev_y_ff      <= prev_y_in;
         prev_left_ff   <= prev_left_in;
         down_region_ff <= down_region_in;
         tap_region_ff  <= tap_region_in;
         down_time_ff   <= down_time_in;
         tap_time_ff    <= tap_time_in;
         single_tap_ff  <= single_tap_in;
      end
   end

endmodule

`default_nettype wire
